@@ rtl/zwc_pkg.sv @@
// Package for the ZNCC window cost block: shared types and fixed widths.
// No dependencies.
package zwc_pkg;
	localparam int PIX_W  = 8;
	localparam int COST_W = 16;

	typedef struct packed {
		logic [PIX_W-1:0] ref_intensity;
		logic [PIX_W-1:0] other_intensity;
		logic             sample_valid;
		logic             last_sample;
	} in_item_t;

	typedef struct packed {
		logic [COST_W-1:0] cost;
		logic              cost_invalid;
	} out_item_t;
endpackage

@@ rtl/zwc_if.sv @@
// Valid/ready channel interfaces for input and result items.
// Depends on zwc_pkg.
interface zwc_in_if;
	logic             valid;
	logic             ready;
	zwc_pkg::in_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface zwc_out_if;
	logic              valid;
	logic              ready;
	zwc_pkg::out_item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

@@ rtl/zwc_accum.sv @@
// Front part: accumulates window sums, one item a cycle (last waits for win_ready), pushes a window record on last.
// Depends on zwc_pkg.
module zwc_accum #(
	parameter int MAX_SAMPLES = 64,
	parameter int CNT_W = 7,
	parameter int S1_W = 14,
	parameter int S2_W = 22
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  zwc_pkg::in_item_t     in_data,
	output logic                  win_valid,
	input  logic                  win_ready,
	output logic [CNT_W-1:0]      win_n,
	output logic [S1_W-1:0]       win_s1,
	output logic [S1_W-1:0]       win_s2,
	output logic [S2_W-1:0]       win_s11,
	output logic [S2_W-1:0]       win_s22,
	output logic [S2_W-1:0]       win_s12,
	output logic                  win_bad
);
	logic [CNT_W-1:0] n_q;
	logic [S1_W-1:0]  s1_q, s2_q;
	logic [S2_W-1:0]  s11_q, s22_q, s12_q;
	logic             bad_q;
	logic             take, acc;
	logic [2*zwc_pkg::PIX_W-1:0] rr, oo, ro;

	assign in_ready = !in_data.last_sample || win_ready || !in_valid;
	assign take = in_valid && in_ready;
	assign acc = in_data.sample_valid && (n_q < CNT_W'(MAX_SAMPLES));
	assign rr = in_data.ref_intensity * in_data.ref_intensity;
	assign oo = in_data.other_intensity * in_data.other_intensity;
	assign ro = in_data.ref_intensity * in_data.other_intensity;

	// window record is the sums including the last item
	assign win_valid = in_valid && in_data.last_sample;
	assign win_n   = acc ? n_q + CNT_W'(1) : n_q;
	assign win_s1  = acc ? s1_q + S1_W'(in_data.ref_intensity) : s1_q;
	assign win_s2  = acc ? s2_q + S1_W'(in_data.other_intensity) : s2_q;
	assign win_s11 = acc ? s11_q + S2_W'(rr) : s11_q;
	assign win_s22 = acc ? s22_q + S2_W'(oo) : s22_q;
	assign win_s12 = acc ? s12_q + S2_W'(ro) : s12_q;
	assign win_bad = bad_q || !acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= '0; s1_q <= '0; s2_q <= '0;
			s11_q <= '0; s22_q <= '0; s12_q <= '0; bad_q <= 1'b0;
		end else if (take) begin
			if (in_data.last_sample) begin
				n_q <= '0; s1_q <= '0; s2_q <= '0;
				s11_q <= '0; s22_q <= '0; s12_q <= '0; bad_q <= 1'b0;
			end else begin
				n_q <= win_n; s1_q <= win_s1; s2_q <= win_s2;
				s11_q <= win_s11; s22_q <= win_s22; s12_q <= win_s12;
				bad_q <= win_bad;
			end
		end
	end
endmodule

@@ rtl/zwc_fifo.sv @@
// Two-entry queue of window records between front and back parts.
// No package dependency.
module zwc_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         not_full,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         not_empty,
	output logic [W-1:0] rdata
);
	logic [W-1:0] mem_q [2];
	logic         wp_q, rp_q;
	logic [1:0]   cnt_q;

	assign not_full = cnt_q != 2'd2;
	assign not_empty = cnt_q != 2'd0;
	assign rdata = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && not_full) mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (push && not_full) wp_q <= !wp_q;
			if (pop && not_empty) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(push && not_full) - 2'(pop && not_empty);
		end
	end
endmodule

@@ rtl/zwc_cost.sv @@
// Back part: moments, bitwise magnitude search over multi-cycle products, cost result register.
// Depends on zwc_pkg.
module zwc_cost #(
	parameter int FRACTION_BITS = 14,
	parameter int CNT_W = 7,
	parameter int S1_W = 14,
	parameter int S2_W = 22
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  rec_valid,
	output logic                  rec_ready,
	input  logic [CNT_W-1:0]      rec_n,
	input  logic [S1_W-1:0]       rec_s1,
	input  logic [S1_W-1:0]       rec_s2,
	input  logic [S2_W-1:0]       rec_s11,
	input  logic [S2_W-1:0]       rec_s22,
	input  logic [S2_W-1:0]       rec_s12,
	input  logic                  rec_bad,
	input  logic [zwc_pkg::COST_W-1:0] invalid_cost,
	output logic                  out_valid,
	input  logic                  out_ready,
	output zwc_pkg::out_item_t    out_data
);
	localparam int MW = CNT_W + S2_W + 1;      // signed moment width
	localparam int KW = FRACTION_BITS + 1;
	localparam int DW = KW + 1;
	localparam int TMW = 2*DW + MW;            // d^2 * v1
	localparam int SPL = TMW / 2;              // split point of d^2*v1 for the v2 product
	localparam int TW = TMW + MW;              // d^2 * v1 * v2
	localparam int SW = $clog2(KW + 1);
	localparam int CW = FRACTION_BITS + 2;

	localparam logic [3:0] ST_IDLE = 4'd0, ST_MUL1 = 4'd1, ST_MUL2 = 4'd2, ST_CHK = 4'd3,
		ST_SRCH = 4'd4, ST_SQ = 4'd5, ST_M1 = 4'd6, ST_M2 = 4'd7, ST_M3 = 4'd8,
		ST_SUM = 4'd9, ST_CMP = 4'd10, ST_OUT = 4'd11;

	logic [3:0] st_q;
	logic [CNT_W-1:0] n_q;
	logic [S1_W-1:0] s1_q, s2_q;
	logic [S2_W-1:0] s11_q, s22_q, s12_q;
	logic bad_q, neg_q;
	logic signed [MW-1:0] num_q, v1_q, v2_q;
	logic signed [MW-1:0] a1_q, a2_q, b1_q, b2_q, c1_q, c2_q;
	logic [MW-1:0] mag, mag_q;
	logic [2*DW-1:0] dsq_q;
	logic [TMW-1:0] t_q;
	logic [SPL+MW-1:0] pl_q;
	logic [TMW-SPL+MW-1:0] ph_q;
	logic [TW-1:0] tgt_q, lhs_q;
	logic [DW-1:0] dval;
	logic [KW-1:0] k_q, cand;
	logic [SW-1:0] bit_q;
	logic out_v_q;
	zwc_pkg::out_item_t res_q;
	logic signed [CW:0] cst;

	assign rec_ready = st_q == ST_IDLE;
	assign out_valid = out_v_q;
	assign out_data = res_q;
	assign cand = k_q | (KW'(1) << bit_q);
	assign dval = (DW'(cand) << 1) - DW'(1);
	assign mag = num_q[MW-1] ? MW'(-num_q) : MW'(num_q);
	assign cst = neg_q ? (CW+1)'((1 << FRACTION_BITS) + k_q) : (CW+1)'((1 << FRACTION_BITS) - k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_v_q <= 1'b0; res_q <= '0;
			n_q <= '0; s1_q <= '0; s2_q <= '0; s11_q <= '0; s22_q <= '0; s12_q <= '0;
			bad_q <= 1'b0; neg_q <= 1'b0;
			num_q <= '0; v1_q <= '0; v2_q <= '0;
			a1_q <= '0; a2_q <= '0; b1_q <= '0; b2_q <= '0; c1_q <= '0; c2_q <= '0;
			mag_q <= '0; dsq_q <= '0; t_q <= '0; pl_q <= '0; ph_q <= '0;
			tgt_q <= '0; lhs_q <= '0; k_q <= '0; bit_q <= '0;
		end else begin
			if (st_q == ST_OUT && (!out_v_q || out_ready)) out_v_q <= 1'b1;
			else if (out_ready) out_v_q <= 1'b0;
			case (st_q)
				ST_IDLE: if (rec_valid) begin
					n_q <= rec_n; s1_q <= rec_s1; s2_q <= rec_s2;
					s11_q <= rec_s11; s22_q <= rec_s22; s12_q <= rec_s12;
					bad_q <= rec_bad || rec_n == '0;
					st_q <= ST_MUL1;
				end
				ST_MUL1: begin
					a1_q <= MW'(n_q * s12_q); a2_q <= MW'(s1_q * s2_q);
					b1_q <= MW'(n_q * s11_q); b2_q <= MW'(s1_q * s1_q);
					c1_q <= MW'(n_q * s22_q); c2_q <= MW'(s2_q * s2_q);
					st_q <= ST_MUL2;
				end
				ST_MUL2: begin
					num_q <= a1_q - a2_q; v1_q <= b1_q - b2_q; v2_q <= c1_q - c2_q;
					st_q <= ST_CHK;
				end
				ST_CHK: begin
					if (bad_q || v1_q <= 0 || v2_q <= 0) begin
						bad_q <= 1'b1; st_q <= ST_OUT;
					end else begin
						mag_q <= mag;
						neg_q <= num_q[MW-1];
						st_q <= ST_SRCH;
					end
				end
				ST_SRCH: begin
					tgt_q <= TW'(mag_q * mag_q) << (2*FRACTION_BITS + 2);
					k_q <= '0; bit_q <= SW'(KW - 1);
					st_q <= ST_SQ;
				end
				// one candidate bit: (2k-1)^2 * v1 * v2 against num^2 * 4^(F+1)
				ST_SQ: begin
					dsq_q <= dval * dval;
					st_q <= ST_M1;
				end
				ST_M1: begin
					t_q <= dsq_q * $unsigned(v1_q);
					st_q <= ST_M2;
				end
				ST_M2: begin
					pl_q <= t_q[SPL-1:0] * $unsigned(v2_q);
					st_q <= ST_M3;
				end
				ST_M3: begin
					ph_q <= t_q[TMW-1:SPL] * $unsigned(v2_q);
					st_q <= ST_SUM;
				end
				ST_SUM: begin
					lhs_q <= (TW'(ph_q) << SPL) + TW'(pl_q);
					st_q <= ST_CMP;
				end
				ST_CMP: begin
					if (lhs_q <= tgt_q && cand <= KW'(1 << FRACTION_BITS))
						k_q <= cand;
					if (bit_q == '0) st_q <= ST_OUT;
					else begin
						bit_q <= bit_q - SW'(1);
						st_q <= ST_SQ;
					end
				end
				ST_OUT: if (!out_v_q || out_ready) begin
					res_q.cost_invalid <= bad_q;
					res_q.cost <= bad_q ? invalid_cost :
						(cst > 65535) ? 16'hffff : 16'(cst);
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ rtl/zncc_window_cost_core.sv @@
// ZNCC window cost top level: accumulator front, record queue, cost back part.
// Depends on zwc_pkg, zwc_if, zwc_accum, zwc_fifo, zwc_cost.
//
//  channel   dir   handshake     payload
//  in_ch     in    valid/ready   ref/other intensity, sample_valid, last_sample
//  out_ch    out   valid/ready   cost, cost_invalid
//  cfg       in    cfg_we        cfg_wdata = invalid_cost
//
// Samples are taken one a cycle unless a last item meets a full queue; a window's cost is
// worked out in the back part by a magnitude search that settles one bit a step, each step
// squaring the candidate, forming the staged products with v1 and v2, then comparing.
// Two window records queue, so accumulation continues while a cost is worked out; a last
// item stalls only while the queue is full. Reset clears sums, queue and state;
// invalid_cost returns to 32768.
module zncc_window_cost_core #(
	parameter int MAX_SAMPLES = 64,
	parameter int FRACTION_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	zwc_in_if.sink      in_ch,
	zwc_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int S1_W = CNT_W + 8;
	localparam int S2_W = CNT_W + 16;
	localparam int RW = CNT_W + 2*S1_W + 3*S2_W + 1;

	logic [15:0] inv_q;
	logic wv, wr, fne, fpop;
	logic [CNT_W-1:0] n;
	logic [S1_W-1:0] s1, s2;
	logic [S2_W-1:0] s11, s22, s12;
	logic bad;
	logic [RW-1:0] rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) inv_q <= 16'h8000;
		else if (cfg_we) inv_q <= cfg_wdata;
	end

	zwc_accum #(.MAX_SAMPLES(MAX_SAMPLES), .CNT_W(CNT_W), .S1_W(S1_W), .S2_W(S2_W)) u_acc (
		.clk, .arst_n, .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.win_valid(wv), .win_ready(wr), .win_n(n), .win_s1(s1), .win_s2(s2),
		.win_s11(s11), .win_s22(s22), .win_s12(s12), .win_bad(bad));

	zwc_fifo #(.W(RW)) u_q (
		.clk, .arst_n, .push(wv), .not_full(wr), .wdata({n, s1, s2, s11, s22, s12, bad}),
		.pop(fpop), .not_empty(fne), .rdata(rd));

	zwc_cost #(.FRACTION_BITS(FRACTION_BITS), .CNT_W(CNT_W), .S1_W(S1_W), .S2_W(S2_W)) u_cost (
		.clk, .arst_n, .rec_valid(fne), .rec_ready(fpop),
		.rec_n(rd[RW-1 -: CNT_W]),
		.rec_s1(rd[RW-CNT_W-1 -: S1_W]),
		.rec_s2(rd[RW-CNT_W-S1_W-1 -: S1_W]),
		.rec_s11(rd[3*S2_W : 2*S2_W+1]),
		.rec_s22(rd[2*S2_W : S2_W+1]),
		.rec_s12(rd[S2_W:1]),
		.rec_bad(rd[0]),
		.invalid_cost(inv_q), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_data(out_ch.data));

`ifndef SYNTHESIS
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
		else $error("result changed under stall");
	a_last_block: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.data.last_sample && !wr |-> !in_ch.ready)
		else $error("last item taken with full queue");
`endif
endmodule
